// ===== design/prrc_pkg.sv =====
// Shared widths, codes, beat types and helpers for the periodic replicate/rotate/cut block.
package prrc_pkg;

  localparam int unsigned ELEM_W     = 8;
  localparam int unsigned TYPE_W     = 4;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned IMG_W      = 25;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PROD_W     = 41;
  localparam int unsigned SUM_W      = 43;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned RND_W      = 29;
  localparam int unsigned ROT_W      = 26;
  localparam int unsigned HBOX_W     = 22;
  localparam int unsigned ROW_W      = 48;
  localparam int unsigned COUNT_W    = 21;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned KEPT_LSB   = ELEM_W + TYPE_W + 3 * ROT_W;

  localparam logic [COUNT_W-1:0]      COUNT_MAX = '1;
  localparam logic signed [SUM_W-1:0] RND_HALF  = 43'sd8192;
  localparam logic signed [RND_W-1:0] ROT_HI    = 29'sd33554431;
  localparam logic signed [RND_W-1:0] ROT_LO    = -29'sd33554432;

  localparam logic [ROW_W-1:0] ROW0_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW1_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 48'h4000_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HBOX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HBOX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HBOX_Z = 3'd5;

  // Image shift along one axis: minus, none or plus one full box.
  typedef enum logic [1:0] {OFS_NEG, OFS_ZERO, OFS_POS} ofs_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [TYPE_W-1:0] kind;
    logic              clr;
    logic              last;
  } meta_t;

  typedef struct packed {
    meta_t                 meta;
    logic [2:0][IMG_W-1:0] img;
  } img_beat_t;

  typedef struct packed {
    meta_t                       meta;
    logic [2:0][2:0][PROD_W-1:0] prod;
  } prod_beat_t;

  typedef struct packed {
    meta_t                 meta;
    logic [2:0][RND_W-1:0] rnd;
  } rnd_beat_t;

  function automatic ofs_t ofs_next(input ofs_t d);
    ofs_t r;
    unique case (d)
      OFS_NEG:  r = OFS_ZERO;
      OFS_ZERO: r = OFS_POS;
      default:  r = OFS_NEG;
    endcase
    return r;
  endfunction

  function automatic logic signed [IMG_W-1:0] img_offset(input ofs_t d,
                                                         input logic [HBOX_W-1:0] h);
    logic signed [IMG_W-1:0] full;
    logic signed [IMG_W-1:0] r;
    full = $signed({2'b00, h, 1'b0});
    unique case (d)
      OFS_NEG: r = -full;
      OFS_POS: r = full;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/prrc_seq.sv =====
// Atom holding register and 27-image sequencer producing shifted image coordinates.
module prrc_seq
  import prrc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [IN_DATA_W-1:0]         in_data,
  input  logic                         in_first,
  input  logic [2:0][HBOX_W-1:0]       hbox,
  output logic                         s0_v,
  output img_beat_t                    s0
);

  logic                   atom_v_r;
  logic [ELEM_W-1:0]      elem_r;
  logic [TYPE_W-1:0]      kind_r;
  logic [2:0][POS_W-1:0]  pos_r;
  logic                   first_r;
  ofs_t                   dx_r, dy_r, dz_r;
  ofs_t                   dx_nxt, dy_nxt, dz_nxt;
  logic                   last_dig;
  logic                   first_dig;
  logic                   issue;
  logic                   accept;
  logic                   s0_v_r;
  img_beat_t              s0_r;
  img_beat_t              s0_nxt;

  assign last_dig  = (dx_r == OFS_POS) && (dy_r == OFS_POS) && (dz_r == OFS_POS);
  assign first_dig = (dx_r == OFS_NEG) && (dy_r == OFS_NEG) && (dz_r == OFS_NEG);
  assign issue     = atom_v_r && adv;
  assign in_ready  = !atom_v_r || (adv && last_dig);
  assign accept    = in_valid && in_ready;

  always_comb begin
    dz_nxt = ofs_next(dz_r);
    dy_nxt = (dz_r == OFS_POS) ? ofs_next(dy_r) : dy_r;
    dx_nxt = (dz_r == OFS_POS && dy_r == OFS_POS) ? ofs_next(dx_r) : dx_r;
  end

  always_comb begin
    s0_nxt.meta.element = elem_r;
    s0_nxt.meta.kind    = kind_r;
    s0_nxt.meta.clr     = first_r && first_dig;
    s0_nxt.meta.last    = last_dig;
    s0_nxt.img[0] = $signed({pos_r[0][POS_W-1], pos_r[0]}) + img_offset(dx_r, hbox[0]);
    s0_nxt.img[1] = $signed({pos_r[1][POS_W-1], pos_r[1]}) + img_offset(dy_r, hbox[1]);
    s0_nxt.img[2] = $signed({pos_r[2][POS_W-1], pos_r[2]}) + img_offset(dz_r, hbox[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_v_r <= 1'b0;
      s0_v_r   <= 1'b0;
      dx_r     <= OFS_NEG;
      dy_r     <= OFS_NEG;
      dz_r     <= OFS_NEG;
    end else begin
      if (accept) begin
        atom_v_r <= 1'b1;
      end else if (issue && last_dig) begin
        atom_v_r <= 1'b0;
      end
      if (accept) begin
        dx_r <= OFS_NEG;
        dy_r <= OFS_NEG;
        dz_r <= OFS_NEG;
      end else if (issue) begin
        dx_r <= dx_nxt;
        dy_r <= dy_nxt;
        dz_r <= dz_nxt;
      end
      if (adv) begin
        s0_v_r <= atom_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elem_r   <= in_data[ELEM_W-1:0];
      kind_r   <= in_data[ELEM_W +: TYPE_W];
      pos_r[0] <= in_data[ELEM_W + TYPE_W +: POS_W];
      pos_r[1] <= in_data[ELEM_W + TYPE_W + POS_W +: POS_W];
      pos_r[2] <= in_data[ELEM_W + TYPE_W + 2 * POS_W +: POS_W];
      first_r  <= in_first;
    end
    if (issue) begin
      s0_r <= s0_nxt;
    end
  end

  assign s0_v = s0_v_r;
  assign s0   = s0_r;

endmodule

// ===== design/prrc_rot.sv =====
// Rotation: registered 3x3 products, then registered row sums rounded to 12 fraction bits.
module prrc_rot
  import prrc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic [2:0][ROW_W-1:0]  matrix,
  input  logic                   s0_v,
  input  img_beat_t              s0,
  output logic                   s2_v,
  output rnd_beat_t              s2
);

  logic                    s1_v_r;
  prod_beat_t              s1_r;
  prod_beat_t              s1_nxt;
  logic                    s2_v_r;
  rnd_beat_t               s2_r;
  rnd_beat_t               s2_nxt;
  logic signed [SUM_W-1:0] acc [3];

  always_comb begin
    s1_nxt.meta = s0.meta;
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        s1_nxt.prod[a][c] = $signed(s0.img[c]) * $signed(matrix[a][c*COEF_W +: COEF_W]);
      end
    end
  end

  always_comb begin
    s2_nxt.meta = s1_r.meta;
    for (int a = 0; a < 3; a++) begin
      acc[a] = $signed(s1_r.prod[a][0]) + $signed(s1_r.prod[a][1])
             + $signed(s1_r.prod[a][2]) + RND_HALF;
      s2_nxt.rnd[a] = acc[a][FRAC_SHIFT +: RND_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s0_v) begin
      s1_r <= s1_nxt;
    end
    if (adv && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_v = s2_v_r;
  assign s2   = s2_r;

endmodule

// ===== design/prrc_clip.sv =====
// Saturation, half-box test, kept-image counter and the output register.
module prrc_clip
  import prrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic [2:0][HBOX_W-1:0]  hbox,
  input  logic                    s2_v,
  input  rnd_beat_t               s2,
  output logic                    out_valid,
  output logic [OUT_DATA_W-1:0]   out_data,
  output logic                    out_inside,
  output logic                    out_last
);

  logic signed [RND_W-1:0] clamp [3];
  logic [2:0][ROT_W-1:0]   sat;
  logic [ROT_W:0]          mag [3];
  logic [2:0]              in_axis;
  logic                    in_box;
  logic [COUNT_W-1:0]      base;
  logic [COUNT_W-1:0]      count_nxt;
  logic [COUNT_W-1:0]      count_r;
  logic                    out_valid_r;
  logic [ELEM_W-1:0]       elem_r;
  logic [TYPE_W-1:0]       kind_r;
  logic [2:0][ROT_W-1:0]   rot_r;
  logic [COUNT_W-1:0]      kept_r;
  logic                    inside_r;
  logic                    last_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if ($signed(s2.rnd[a]) > ROT_HI) begin
        clamp[a] = ROT_HI;
      end else if ($signed(s2.rnd[a]) < ROT_LO) begin
        clamp[a] = ROT_LO;
      end else begin
        clamp[a] = $signed(s2.rnd[a]);
      end
      sat[a] = clamp[a][ROT_W-1:0];
      mag[a] = sat[a][ROT_W-1] ? (~{sat[a][ROT_W-1], sat[a]} + 1'b1)
                               : {sat[a][ROT_W-1], sat[a]};
      in_axis[a] = mag[a][ROT_W-1:0] < {{(ROT_W-HBOX_W){1'b0}}, hbox[a]};
    end
  end

  assign in_box    = &in_axis;
  assign base      = s2.meta.clr ? '0 : count_r;
  assign count_nxt = (in_box && base != COUNT_MAX) ? base + 1'b1 : base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else if (adv) begin
      out_valid_r <= s2_v;
      if (s2_v) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v) begin
      elem_r   <= s2.meta.element;
      kind_r   <= s2.meta.kind;
      rot_r    <= sat;
      kept_r   <= count_nxt;
      inside_r <= in_box;
      last_r   <= s2.meta.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = {1'b0, kept_r, rot_r, kind_r, elem_r};
  assign out_inside = inside_r;
  assign out_last   = last_r;

endmodule

// ===== design/periodic_replicate_rotate_cut.sv =====
// Top level: config registers, image sequencer, rotation pipeline and box clip.
//
// Usage: one input beat carries an atom (element, type, position x/y/z in
// signed Q.12) with in_tuser set on the first atom of a sample. The block
// emits 27 output beats per atom, the periodic images shifted by -1/0/+1 box
// lengths (x outermost, z innermost), each rotated by the 3x3 Q1.14 matrix,
// saturated to 26 bits and flagged in out_tuser when strictly inside the
// half box. out_tlast marks the 27th image; kept_total is the running count.
// Throughput: one image per cycle while the receiver takes them; the image
// sequencer holds one atom while it issues its images and takes the next atom
// in the cycle its last image issues. Each image passes the shift, products,
// row sums and clip/output registers in turn after the input beat is accepted.
// A receiver stall (out_tready low with out_tvalid high) freezes the whole
// pipeline; nothing is dropped. Config writes are taken at any time
// (cfg_ready is tied high) and must only be issued while idle.
// Reset (rst_n low, synchronous) loads the identity matrix, zero half box,
// clears the kept count and empties every stage.
module periodic_replicate_rotate_cut
  import prrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // element[7:0], type[11:8], pos_x[35:12], pos_y[59:36], pos_z[83:60], pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // first_of_sample[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_element[7:0], out_type[11:8], rot_x[37:12], rot_y[63:38],
  // rot_z[89:64], kept_total[110:90], pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // inside_box[0]
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ROW_W-1:0]      cfg_data
);

  logic [2:0][ROW_W-1:0]  matrix_r;
  logic [2:0][HBOX_W-1:0] hbox_r;
  logic                   adv;
  logic                   s0_v;
  img_beat_t              s0;
  logic                   s2_v;
  rnd_beat_t              s2;

  assign cfg_ready = 1'b1;
  assign adv       = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r[0] <= ROW0_RST;
      matrix_r[1] <= ROW1_RST;
      matrix_r[2] <= ROW2_RST;
      hbox_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0:   matrix_r[0] <= cfg_data;
        REG_ROW1:   matrix_r[1] <= cfg_data;
        REG_ROW2:   matrix_r[2] <= cfg_data;
        REG_HBOX_X: hbox_r[0]   <= cfg_data[HBOX_W-1:0];
        REG_HBOX_Y: hbox_r[1]   <= cfg_data[HBOX_W-1:0];
        REG_HBOX_Z: hbox_r[2]   <= cfg_data[HBOX_W-1:0];
        default: ;
      endcase
    end
  end

  prrc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .in_first (in_tuser),
    .hbox     (hbox_r),
    .s0_v     (s0_v),
    .s0       (s0)
  );

  prrc_rot u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .matrix (matrix_r),
    .s0_v   (s0_v),
    .s0     (s0),
    .s2_v   (s2_v),
    .s2     (s2)
  );

  prrc_clip u_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .hbox       (hbox_r),
    .s2_v       (s2_v),
    .s2         (s2),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .out_inside (out_tuser),
    .out_last   (out_tlast)
  );

  // An inside image is counted and the count saturates rather than wraps, so the kept total cannot be zero.
  a_kept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser |-> out_tdata[KEPT_LSB +: COUNT_W] != '0)
    else $error("inside image reported with zero kept total");

  // A fresh atom keeps the sequencer busy for its remaining images.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new atom accepted while images still pending");

endmodule

// ===== sim/prrc_checker.sv =====
// Scoreboard for periodic_replicate_rotate_cut: predicts the 27 images of each atom and checks every output beat.
module prrc_checker
  import prrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ROW_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    images_due
);

  localparam longint ROT_TOP = 64'sd33554431;
  localparam longint ROT_BOT = -64'sd33554432;

  typedef struct packed {
    logic [ELEM_W-1:0]         element;
    logic [TYPE_W-1:0]         kind;
    logic [2:0][ROT_W-1:0]     rot;
    logic                      in_box;
    logic [COUNT_W-1:0]        kept;
    logic                      last;
  } image_t;

  logic [ROW_W-1:0]   rot_row [3];
  logic [HBOX_W-1:0]  half_box [3];
  logic [COUNT_W-1:0] kept_count;
  image_t             image_q [$];
  int                 err_count = 0;

  // Expand one atom into its 27 shifted, rotated and clipped images.
  task automatic replicate_atom(input logic [IN_DATA_W-1:0] d, input logic first);
    logic signed [POS_W-1:0]  pos [3];
    logic signed [COEF_W-1:0] cf;
    longint                   img [3];
    longint                   hb [3];
    longint                   acc, r, mag;
    int                       n;
    image_t                   im;
    pos[0] = d[ELEM_W+TYPE_W +: POS_W];
    pos[1] = d[ELEM_W+TYPE_W+POS_W +: POS_W];
    pos[2] = d[ELEM_W+TYPE_W+2*POS_W +: POS_W];
    for (int a = 0; a < 3; a++) hb[a] = half_box[a];
    if (first) kept_count = '0;
    n = 0;
    for (int i = -1; i <= 1; i++) begin
      for (int j = -1; j <= 1; j++) begin
        for (int k = -1; k <= 1; k++) begin
          img[0] = longint'(pos[0]) + i * 2 * hb[0];
          img[1] = longint'(pos[1]) + j * 2 * hb[1];
          img[2] = longint'(pos[2]) + k * 2 * hb[2];
          im.in_box = 1'b1;
          for (int a = 0; a < 3; a++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
              cf = rot_row[a][COEF_W*c +: COEF_W];
              acc += img[c] * cf;
            end
            r = (acc + 8192) >>> FRAC_SHIFT;
            if (r > ROT_TOP) r = ROT_TOP;
            if (r < ROT_BOT) r = ROT_BOT;
            mag = (r < 0) ? -r : r;
            if (!(mag < hb[a])) im.in_box = 1'b0;
            im.rot[a] = r[ROT_W-1:0];
          end
          if (im.in_box && kept_count != COUNT_MAX) kept_count++;
          im.element = d[ELEM_W-1:0];
          im.kind    = d[ELEM_W +: TYPE_W];
          im.kept    = kept_count;
          im.last    = (n == 26);
          image_q.push_back(im);
          n++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    image_t want;
    if (!rst_n) begin
      rot_row[0] = ROW0_RST;
      rot_row[1] = ROW1_RST;
      rot_row[2] = ROW2_RST;
      for (int a = 0; a < 3; a++) half_box[a] = '0;
      kept_count = '0;
      image_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW0:   rot_row[0]  = cfg_data;
          REG_ROW1:   rot_row[1]  = cfg_data;
          REG_ROW2:   rot_row[2]  = cfg_data;
          REG_HBOX_X: half_box[0] = cfg_data[HBOX_W-1:0];
          REG_HBOX_Y: half_box[1] = cfg_data[HBOX_W-1:0];
          REG_HBOX_Z: half_box[2] = cfg_data[HBOX_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) replicate_atom(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (image_q.size() == 0) begin
          $display("%0t: unexpected image beat, actual %0h", $time, out_tdata);
          err_count++;
        end else begin
          want = image_q.pop_front();
          check_field("element", want.element, out_tdata[ELEM_W-1:0]);
          check_field("type", want.kind, out_tdata[ELEM_W +: TYPE_W]);
          check_field("rot_x", want.rot[0], out_tdata[ELEM_W+TYPE_W +: ROT_W]);
          check_field("rot_y", want.rot[1], out_tdata[ELEM_W+TYPE_W+ROT_W +: ROT_W]);
          check_field("rot_z", want.rot[2], out_tdata[ELEM_W+TYPE_W+2*ROT_W +: ROT_W]);
          check_field("kept_total", want.kept, out_tdata[KEPT_LSB +: COUNT_W]);
          check_field("inside_box", want.in_box, out_tuser);
          check_field("last_image", want.last, out_tlast);
        end
      end
    end
    mismatches <= err_count;
    images_due <= image_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: clock, reset, atom and register stimulus for periodic_replicate_rotate_cut, and the verdict.
module tb_top;
  import prrc_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_PHASES   = 8;
  localparam int ATOMS_PER_PHASE = 49;
  localparam logic [HBOX_W-1:0] HBOX_MAX = '1;

  typedef enum {MAT_IDENTITY, MAT_ROTATION, MAT_RANDOM, MAT_EXTREME} matrix_kind_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ROW_W-1:0]      cfg_data;

  int                mismatches;
  int                images_due;
  bit                idle_on = 1'b1;
  int                holds_asked = 0;
  int                holds_done = 0;
  int                quiet_cycles = 0;
  logic [HBOX_W-1:0] box_cur [3];

  always #2 clk = ~clk;

  periodic_replicate_rotate_cut dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  prrc_checker image_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .images_due(images_due)
  );

  // Image receiver: random back-pressure plus one long hold-off on request.
  initial begin : image_sink
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= !(idle_on && $urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                   (cfg_valid && cfg_ready)))
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[periodic_replicate_rotate_cut] ERROR");
      $finish;
    end
  end

  task automatic send_atom(input logic [ELEM_W-1:0] elem, input logic [TYPE_W-1:0] kind,
                           input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [POS_W-1:0] z, input logic first);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({z, y, x, kind, elem});
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_geometry(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                              input logic [ROW_W-1:0] r2, input logic [HBOX_W-1:0] hx,
                              input logic [HBOX_W-1:0] hy, input logic [HBOX_W-1:0] hz);
    write_reg(REG_ROW0, r0);
    write_reg(REG_ROW1, r1);
    write_reg(REG_ROW2, r2);
    write_reg(REG_HBOX_X, ROW_W'(hx));
    write_reg(REG_HBOX_Y, ROW_W'(hy));
    write_reg(REG_HBOX_Z, ROW_W'(hz));
    cfg_valid <= 1'b0;
    box_cur[0] = hx;
    box_cur[1] = hy;
    box_cur[2] = hz;
  endtask

  // Stop offering atoms until every image has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (images_due != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [ROW_W-1:0] random_row(input int a, input matrix_kind_e mk);
    logic [ROW_W-1:0] r;
    for (int c = 0; c < 3; c++) begin
      case (mk)
        MAT_IDENTITY: r[COEF_W*c +: COEF_W] = (c == a) ? 16'h4000 : 16'h0000;
        MAT_ROTATION: r[COEF_W*c +: COEF_W] = COEF_W'($urandom_range(0, 32768) - 16384);
        MAT_RANDOM:   r[COEF_W*c +: COEF_W] = COEF_W'($urandom);
        default: begin
          case ($urandom_range(0, 3))
            0:       r[COEF_W*c +: COEF_W] = 16'h7FFF;
            1:       r[COEF_W*c +: COEF_W] = 16'h8000;
            2:       r[COEF_W*c +: COEF_W] = 16'hFFFF;
            default: r[COEF_W*c +: COEF_W] = 16'h0000;
          endcase
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [HBOX_W-1:0] random_half_box();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return HBOX_MAX;
      2, 3:    return HBOX_W'($urandom_range(1, 262144));
      default: return HBOX_W'($urandom_range(1, HBOX_MAX));
    endcase
  endfunction

  // Mostly positions near the half box so images land on both sides of the clip.
  task automatic random_atom(input logic first);
    logic [POS_W-1:0] p [3];
    int unsigned      span;
    bit               tidy;
    tidy = $urandom_range(0, 99) < 80;
    for (int a = 0; a < 3; a++) begin
      span = box_cur[a] + box_cur[a] / 4 + 1;
      p[a] = tidy ? POS_W'($urandom_range(0, 2 * span) - span) : POS_W'($urandom);
    end
    send_atom(ELEM_W'($urandom), TYPE_W'($urandom), p[0], p[1], p[2], first);
  endtask

  initial begin : stimulus
    matrix_kind_e mk;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int a = 0; a < 3; a++) box_cur[a] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: identity, zero half box
    send_atom(8'hFF, 4'hF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_atom(8'h00, 4'h0, 24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_atom(8'hA5, 4'h5, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_atom(8'h5A, 4'hA, 24'h555555, 24'hAAAAAA, 24'h555555, 1'b1);
    wait_drained();

    // identity, half box 10.0: points on and just inside the bounds
    set_geometry(ROW0_RST, ROW1_RST, ROW2_RST, 22'd40960, 22'd40960, 22'd40960);
    send_atom(8'h01, 4'h0, 24'd0, 24'd0, 24'd0, 1'b1);
    send_atom(8'hFF, 4'hF, 24'd40960, 24'd0, 24'd0, 1'b0);
    send_atom(8'h80, 4'h8, 24'd40959, POS_W'(-40959), 24'd40959, 1'b0);
    send_atom(8'h7F, 4'h7, POS_W'(-40960), 24'd40959, 24'd0, 1'b0);
    send_atom(8'h10, 4'h1, 24'd81919, POS_W'(-81919), 24'd0, 1'b0);
    send_atom(8'h11, 4'h2, 24'd0, 24'd0, 24'd40960, 1'b1);
    wait_drained();

    // half-scale diagonal: exact rounding ties
    set_geometry(48'h0000_0000_2000, 48'h0000_2000_0000, 48'h2000_0000_0000,
                 22'd4096, 22'd4096, 22'd4096);
    send_atom(8'h20, 4'h3, 24'd1, POS_W'(-1), 24'd3, 1'b1);
    send_atom(8'h21, 4'h4, POS_W'(-3), 24'd2, POS_W'(-2), 1'b0);
    send_atom(8'h22, 4'h6, 24'd8191, POS_W'(-8191), 24'd0, 1'b0);
    wait_drained();

    // full-scale coefficients and largest box: saturation
    set_geometry({16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h8000, 16'h8000, 16'h8000},
                 {16'h0000, 16'h8000, 16'h7FFF}, HBOX_MAX, HBOX_MAX, HBOX_MAX);
    send_atom(8'h30, 4'h9, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_atom(8'h31, 4'hB, 24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_atom(8'h32, 4'hC, 24'h7FFFFF, 24'h800000, 24'h000000, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       mk = MAT_EXTREME;
        1:       mk = MAT_ROTATION;
        2:       mk = MAT_IDENTITY;
        default: mk = matrix_kind_e'($urandom_range(0, 3));
      endcase
      set_geometry(random_row(0, mk), random_row(1, mk), random_row(2, mk),
                   (ph == 0) ? '0 : random_half_box(),
                   (ph == 0) ? HBOX_MAX : random_half_box(), random_half_box());
      if (ph == 1) holds_asked++;
      idle_on = (ph != 2);
      for (int n = 0; n < ATOMS_PER_PHASE; n++)
        random_atom(n == 0 || $urandom_range(0, 99) < 5);
      wait_drained();
    end
    idle_on = 1'b1;

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("[periodic_replicate_rotate_cut] OK");
    else
      $display("[periodic_replicate_rotate_cut] ERROR");
    $finish;
  end

endmodule
